// ===== rtl/dpst_pkg.sv =====
// Shared types and constants for the dual pattern scroll timer.
`default_nettype none

package dpst_pkg;

	localparam int SPEED_W    = 8;
	localparam int PERIOD_W   = 9;
	localparam int TPS_W      = 20;
	localparam int IN_TIME_W  = 32;
	localparam int OFFSET_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [TPS_W-1:0]    TPS_RESET    = 20'd1000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd1;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_SKIP   = 2'd1,
		OP_INIT   = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOR_SPEED  = 3'd0,
		REG_DIM_SPEED    = 3'd1,
		REG_COLOR_PERIOD = 3'd2,
		REG_DIM_PERIOD   = 3'd3,
		REG_TPS          = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [IN_TIME_W-1:0] time_value;
	} req_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] color_offset;
		logic [OFFSET_W-1:0] dim_offset;
		logic [OFFSET_W-1:0] hue_count;
		logic                color_ready;
		logic                dim_ready;
		logic                color_moved;
		logic                dim_moved;
	} rsp_t;

	typedef struct packed {
		logic [SPEED_W-1:0]  color_speed;
		logic [SPEED_W-1:0]  dim_speed;
		logic [PERIOD_W-1:0] color_period;
		logic [PERIOD_W-1:0] dim_period;
		logic [TPS_W-1:0]    ticks_per_second;
		logic                color_clr;
		logic                dim_clr;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/dpst_div.sv =====
// Bit-serial restoring divider shared by both channels for the step size.
`default_nettype none

module dpst_div import dpst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [TPS_W-1:0]   dividend,
	input  wire logic [SPEED_W-1:0] divisor,
	output logic                    done,
	output logic [TPS_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(TPS_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SPEED_W-1:0] rem_q;
	logic [TPS_W-1:0]   quo_q;
	logic [SPEED_W-1:0] dvs_q;

	logic [SPEED_W:0]   shifted;
	logic [SPEED_W+1:0] diff;
	logic               fits;

	assign shifted = {rem_q, quo_q[TPS_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !diff[SPEED_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TPS_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SPEED_W-1:0] : shifted[SPEED_W-1:0];
			quo_q <= {quo_q[TPS_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/dpst_core.sv =====
// Sequencer, channel state and response register of the scroll timer.
`default_nettype none

module dpst_core import dpst_pkg::*; #(
	parameter int MAX_PERIOD = 256,
	parameter int TIME_BITS  = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int TW    = TIME_BITS;
	localparam int CW    = (TIME_BITS > TPS_W) ? TIME_BITS : TPS_W;
	localparam int OFF_W = (MAX_PERIOD > 512) ? 9 : $clog2(MAX_PERIOD);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SKIP,
		S_DIM_START,
		S_DIM_WAIT,
		S_DIM_UPD,
		S_COL_START,
		S_COL_WAIT,
		S_COL_UPD,
		S_DONE
	} state_t;

	function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
		logic [PERIOD_W-1:0] r;
		if (p == '0) begin
			r = PERIOD_W'(1);
		end else if (32'(p) > 32'(MAX_PERIOD)) begin
			r = PERIOD_W'(MAX_PERIOD);
		end else begin
			r = p;
		end
		return r;
	endfunction

	function automatic logic [OFF_W-1:0] move_offset(input logic [OFF_W-1:0] off,
			input logic [PERIOD_W-1:0] period, input logic fwd);
		logic [PERIOD_W:0] oe;
		logic [PERIOD_W:0] pe;
		logic [PERIOD_W:0] r;
		oe = (PERIOD_W+1)'(off);
		pe = (PERIOD_W+1)'(eff_period(period));
		if (fwd) begin
			r = (oe == '0 || oe >= pe) ? pe - 1'b1 : oe - 1'b1;
		end else begin
			r = (oe + 1'b1 >= pe) ? '0 : oe + 1'b1;
		end
		return OFF_W'(r);
	endfunction

	state_t             state_q;
	logic [TW-1:0]      tv_q;
	logic [TW-1:0]      color_last_q;
	logic [TW-1:0]      dim_last_q;
	logic [OFF_W-1:0]   color_first_q;
	logic [OFF_W-1:0]   dim_first_q;
	logic [OFFSET_W-1:0] hue_q;
	logic               due_q;
	logic               color_ready_q;
	logic               dim_ready_q;
	logic               color_moved_q;
	logic               dim_moved_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               div_start;
	logic               div_done;
	logic [TPS_W-1:0]   step;
	logic [SPEED_W-1:0] speed_sel;
	logic [SPEED_W-1:0] mag_sel;
	logic [TW-1:0]      last_sel;
	logic [TW-1:0]      elapsed;
	logic               due;
	logic               col_phase;

	assign col_phase = (state_q == S_COL_START) || (state_q == S_COL_WAIT);
	assign speed_sel = col_phase ? cfg.color_speed : cfg.dim_speed;
	assign mag_sel   = speed_sel[SPEED_W-1] ? SPEED_W'(-speed_sel) : speed_sel;
	assign last_sel  = col_phase ? color_last_q : dim_last_q;
	assign elapsed   = tv_q - last_sel;
	assign due       = CW'(elapsed) >= CW'(step);
	assign div_start = ((state_q == S_DIM_START) && (cfg.dim_speed != '0)) ||
		((state_q == S_COL_START) && (cfg.color_speed != '0));

	dpst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cfg.ticks_per_second),
		.divisor  (mag_sel),
		.done     (div_done),
		.quotient (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tv_q          <= '0;
			color_last_q  <= '0;
			dim_last_q    <= '0;
			color_first_q <= '0;
			dim_first_q   <= '0;
			hue_q         <= '0;
			due_q         <= 1'b0;
			color_ready_q <= 1'b0;
			dim_ready_q   <= 1'b0;
			color_moved_q <= 1'b0;
			dim_moved_q   <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.color_clr) begin
				color_first_q <= '0;
			end
			if (cfg.dim_clr) begin
				dim_first_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						tv_q          <= TW'(req.time_value);
						color_ready_q <= 1'b0;
						dim_ready_q   <= 1'b0;
						color_moved_q <= 1'b0;
						dim_moved_q   <= 1'b0;
						case (req.opcode)
							OP_UPDATE: state_q <= S_DIM_START;
							OP_SKIP:   state_q <= S_SKIP;
							OP_INIT: begin
								color_first_q <= '0;
								dim_first_q   <= '0;
								color_last_q  <= TW'(req.time_value);
								dim_last_q    <= TW'(req.time_value);
								state_q       <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SKIP: begin
					color_last_q <= color_last_q + tv_q;
					dim_last_q   <= dim_last_q + tv_q;
					state_q      <= S_DONE;
				end
				S_DIM_START: begin
					if (cfg.dim_speed == '0) begin
						dim_last_q  <= tv_q;
						dim_ready_q <= 1'b1;
						state_q     <= S_COL_START;
					end else begin
						state_q <= S_DIM_WAIT;
					end
				end
				S_DIM_WAIT: begin
					if (div_done) begin
						due_q   <= due;
						state_q <= S_DIM_UPD;
					end
				end
				S_DIM_UPD: begin
					dim_ready_q <= due_q;
					dim_moved_q <= due_q;
					if (due_q) begin
						dim_first_q <= move_offset(dim_first_q, cfg.dim_period,
							!cfg.dim_speed[SPEED_W-1]);
						dim_last_q  <= dim_last_q + TW'(step);
					end
					state_q <= S_COL_START;
				end
				S_COL_START: begin
					if (cfg.color_speed == '0) begin
						color_last_q  <= tv_q;
						color_ready_q <= 1'b1;
						state_q       <= S_DONE;
					end else begin
						state_q <= S_COL_WAIT;
					end
				end
				S_COL_WAIT: begin
					if (div_done) begin
						due_q   <= due;
						state_q <= S_COL_UPD;
					end
				end
				S_COL_UPD: begin
					color_ready_q <= due_q;
					color_moved_q <= due_q;
					if (due_q) begin
						color_first_q <= move_offset(color_first_q, cfg.color_period,
							!cfg.color_speed[SPEED_W-1]);
						color_last_q  <= color_last_q + TW'(step);
						hue_q         <= cfg.color_speed[SPEED_W-1] ?
							hue_q - 1'b1 : hue_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.color_offset <= OFFSET_W'(color_first_q);
						rsp_q.dim_offset   <= OFFSET_W'(dim_first_q);
						rsp_q.hue_count    <= hue_q;
						rsp_q.color_ready  <= color_ready_q;
						rsp_q.dim_ready    <= dim_ready_q;
						rsp_q.color_moved  <= color_moved_q;
						rsp_q.dim_moved    <= dim_moved_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIM_WAIT) || (state_q == S_COL_WAIT))
		else $error("divider finished outside a wait state");

	a_moved_implies_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.color_moved || rsp.color_ready) &&
		(!rsp.dim_moved || rsp.dim_ready))
		else $error("offset moved without step due");

	a_no_start_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == S_DIM_WAIT) || (state_q == S_COL_WAIT))
		else $error("divider started without waiting on it");

endmodule

`default_nettype wire

// ===== rtl/dual_pattern_scroll_timer_top.sv =====
// Top level of the dual pattern scroll timer: configuration registers and core.
//
// Requests arrive on req_valid/req_ready with req (opcode, time_value); each
// request produces one response on rsp_valid/rsp_ready with rsp holding both
// offsets, the hue counter and the ready and moved flags.
// An update request runs the step size ticks_per_second / |speed| through one
// shared bit-serial divider, one quotient bit per cycle, once for each
// channel with nonzero speed, dim before colour. The response is then
// registered in S_DONE; skip, init, and updates with both speeds zero
// reach S_DONE without using the divider.
// One request is in flight at a time; req_ready is low from acceptance
// until the response has been loaded into the output register.
// A stalled receiver holds the response; the next request is still taken,
// and its response waits until the output register frees.
// Configuration is written through cfg_we/cfg_index/cfg_wdata,
// and a period write with a new value zeroes that channel's offset.
// Reset clears offsets, last-move times and hue, and loads the register
// defaults: speeds 0, periods 1, ticks_per_second 1000.
`default_nettype none

module dual_pattern_scroll_timer_top import dpst_pkg::*; #(
	parameter int MAX_PERIOD = 256,
	parameter int TIME_BITS  = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output rsp_t                       rsp
);

	logic [SPEED_W-1:0]  color_speed_q;
	logic [SPEED_W-1:0]  dim_speed_q;
	logic [PERIOD_W-1:0] color_period_q;
	logic [PERIOD_W-1:0] dim_period_q;
	logic [TPS_W-1:0]    tps_q;
	cfg_t                cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_speed_q  <= '0;
			dim_speed_q    <= '0;
			color_period_q <= PERIOD_RESET;
			dim_period_q   <= PERIOD_RESET;
			tps_q          <= TPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOR_SPEED:  color_speed_q  <= cfg_wdata[SPEED_W-1:0];
				REG_DIM_SPEED:    dim_speed_q    <= cfg_wdata[SPEED_W-1:0];
				REG_COLOR_PERIOD: color_period_q <= cfg_wdata[PERIOD_W-1:0];
				REG_DIM_PERIOD:   dim_period_q   <= cfg_wdata[PERIOD_W-1:0];
				REG_TPS:          tps_q          <= cfg_wdata[TPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.color_speed      = color_speed_q;
		cfg.dim_speed        = dim_speed_q;
		cfg.color_period     = color_period_q;
		cfg.dim_period       = dim_period_q;
		cfg.ticks_per_second = tps_q;
		cfg.color_clr        = cfg_we && (cfg_index == REG_COLOR_PERIOD) &&
			(cfg_wdata[PERIOD_W-1:0] != color_period_q);
		cfg.dim_clr          = cfg_we && (cfg_index == REG_DIM_PERIOD) &&
			(cfg_wdata[PERIOD_W-1:0] != dim_period_q);
	end

	dpst_core #(
		.MAX_PERIOD (MAX_PERIOD),
		.TIME_BITS  (TIME_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== tb/dpst_checker.sv =====
// Response checker for the dual pattern scroll timer: tracks registers, predicts and compares.
`default_nettype none

module dpst_checker import dpst_pkg::*; #(
	parameter int MAX_PERIOD = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire req_t                  req,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	input  wire rsp_t                  rsp,
	output int                         fail_count,
	output int                         outstanding,
	output int                         checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [SPEED_W-1:0]   color_speed, dim_speed;
	logic [PERIOD_W-1:0]  color_period, dim_period;
	logic [TPS_W-1:0]     tps;
	logic [OFFSET_W-1:0]  color_first, dim_first, hue;
	logic [IN_TIME_W-1:0] color_last, dim_last;
	rsp_t                 pending_views[$];

	function automatic logic [TPS_W-1:0] step_ticks(input logic [SPEED_W-1:0] s);
		logic [SPEED_W:0] mag;
		mag = s[SPEED_W-1] ? (9'd256 - {1'b0, s}) : {1'b0, s};
		return tps / mag;
	endfunction

	function automatic logic is_due(input logic [SPEED_W-1:0] s,
			input logic [IN_TIME_W-1:0] last, input logic [IN_TIME_W-1:0] now);
		logic [IN_TIME_W-1:0] elapsed;
		if (s == '0) begin
			return 1'b1;
		end
		elapsed = now - last;
		return elapsed >= step_ticks(s);
	endfunction

	function automatic logic step_channel(input logic [SPEED_W-1:0] s,
			input logic [PERIOD_W-1:0] p, input logic [IN_TIME_W-1:0] now,
			inout logic [IN_TIME_W-1:0] last, inout logic [OFFSET_W-1:0] off);
		logic [9:0]           ep;
		logic [9:0]           o;
		logic [9:0]           nxt;
		logic [IN_TIME_W-1:0] elapsed;
		logic [TPS_W-1:0]     st;
		if (s == '0) begin
			last = now;
			return 1'b0;
		end
		st = step_ticks(s);
		elapsed = now - last;
		if (elapsed < st) begin
			return 1'b0;
		end
		if (p == '0) ep = 10'd1;
		else if (p > MAX_PERIOD) ep = 10'(MAX_PERIOD);
		else ep = {1'b0, p};
		o = {2'b00, off};
		if (!s[SPEED_W-1]) nxt = (o == 0 || o >= ep) ? ep - 10'd1 : o - 10'd1;
		else nxt = (o + 10'd1 >= ep) ? 10'd0 : o + 10'd1;
		off = nxt[OFFSET_W-1:0];
		last = last + st;
		return 1'b1;
	endfunction

	function automatic rsp_t advance_scroll(input req_t r);
		rsp_t e;
		e = '0;
		case (r.opcode)
			OP_UPDATE: begin
				e.color_ready = is_due(color_speed, color_last, r.time_value);
				e.dim_ready   = is_due(dim_speed, dim_last, r.time_value);
				e.dim_moved   = step_channel(dim_speed, dim_period, r.time_value,
					dim_last, dim_first);
				e.color_moved = step_channel(color_speed, color_period, r.time_value,
					color_last, color_first);
				if (e.color_moved) hue = color_speed[SPEED_W-1] ? hue - 1'b1 : hue + 1'b1;
			end
			OP_SKIP: begin
				color_last = color_last + r.time_value;
				dim_last   = dim_last + r.time_value;
			end
			OP_INIT: begin
				color_first = '0;
				dim_first   = '0;
				color_last  = r.time_value;
				dim_last    = r.time_value;
			end
			default: ;
		endcase
		e.color_offset = color_first;
		e.dim_offset   = dim_first;
		e.hue_count    = hue;
		return e;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			color_speed = '0;
			dim_speed = '0;
			color_period = PERIOD_RESET;
			dim_period = PERIOD_RESET;
			tps = TPS_RESET;
			color_first = '0;
			dim_first = '0;
			hue = '0;
			color_last = '0;
			dim_last = '0;
			pending_views.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COLOR_SPEED: color_speed = cfg_wdata[SPEED_W-1:0];
					REG_DIM_SPEED: dim_speed = cfg_wdata[SPEED_W-1:0];
					REG_COLOR_PERIOD: begin
						if (cfg_wdata[PERIOD_W-1:0] != color_period) color_first = '0;
						color_period = cfg_wdata[PERIOD_W-1:0];
					end
					REG_DIM_PERIOD: begin
						if (cfg_wdata[PERIOD_W-1:0] != dim_period) dim_first = '0;
						dim_period = cfg_wdata[PERIOD_W-1:0];
					end
					REG_TPS: tps = cfg_wdata[TPS_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_views.size() == 0) begin
					$error("response with no request pending");
					fail_count++;
				end else begin
					want = pending_views.pop_front();
					check_field("color_offset", want.color_offset, rsp.color_offset);
					check_field("dim_offset", want.dim_offset, rsp.dim_offset);
					check_field("hue_count", want.hue_count, rsp.hue_count);
					check_field("color_ready", want.color_ready, rsp.color_ready);
					check_field("dim_ready", want.dim_ready, rsp.dim_ready);
					check_field("color_moved", want.color_moved, rsp.color_moved);
					check_field("dim_moved", want.dim_moved, rsp.dim_moved);
					checked_count++;
				end
			end
			if (req_valid && req_ready) pending_views.push_back(advance_scroll(req));
		end
		outstanding = pending_views.size();
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for the dual pattern scroll timer: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dpst_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp;
	int                    fail_count;
	int                    outstanding;
	int                    checked_count;

	int                    send_idle_pct;
	int                    recv_stall_pct;
	int                    hold_request;
	int                    sent_count;
	int                    settings_count;
	logic [IN_TIME_W-1:0]  now_time;
	logic [SPEED_W-1:0]    cur_cs, cur_ds;
	logic [TPS_W-1:0]      cur_tps;

	dual_pattern_scroll_timer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	dpst_checker scroll_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != hold_seen) begin
				hold_left = hold_request;
				hold_seen = hold_request;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
			end
		end
	end

	task automatic send_req(input logic [1:0] op, input logic [IN_TIME_W-1:0] tv);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{opcode: op, time_value: tv};
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic apply_settings(input int cs, input int ds, input int cp, input int dp,
			input int tps);
		reg_idx_t idx [5];
		int       val [5];
		drain();
		idx = '{REG_COLOR_SPEED, REG_DIM_SPEED, REG_COLOR_PERIOD, REG_DIM_PERIOD, REG_TPS};
		val = '{cs, ds, cp, dp, tps};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= CFG_DATA_W'(val[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cur_cs = SPEED_W'(cs);
		cur_ds = SPEED_W'(ds);
		cur_tps = TPS_W'(tps);
		settings_count++;
	endtask

	task automatic run_random(input int n, input int idle, input int stall,
			input int drain_every);
		int                   mag;
		int                   hint;
		int                   pick;
		logic [1:0]           op;
		logic [IN_TIME_W-1:0] tv;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		mag = cur_cs[SPEED_W-1] ? 256 - cur_cs : cur_cs;
		if (mag == 0) mag = cur_ds[SPEED_W-1] ? 256 - cur_ds : cur_ds;
		if (mag == 0) mag = 1;
		hint = cur_tps / mag;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 75) begin
				now_time += $urandom_range(2 * hint + 2, 0);
				op = OP_UPDATE;
				tv = now_time;
			end else if (pick < 85) begin
				op = OP_SKIP;
				tv = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(hint, 0);
			end else if (pick < 92) begin
				if ($urandom_range(1, 0)) now_time = $urandom();
				op = OP_INIT;
				tv = now_time;
			end else if (pick < 96) begin
				op = OP_UPDATE;
				tv = $urandom();
			end else begin
				op = OP_SPARE;
				tv = $urandom();
			end
			send_req(op, tv);
			if (drain_every != 0 && i % drain_every == drain_every - 1) drain();
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COLOR_SPEED;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		sent_count = 0;
		settings_count = 0;
		now_time = '0;
		cur_cs = '0;
		cur_ds = '0;
		cur_tps = TPS_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: both speeds zero
		send_req(OP_UPDATE, 32'h0000_0000);
		send_req(OP_UPDATE, 32'hFFFF_FFFF);
		send_req(OP_SKIP, 32'hFFFF_FFFF);
		send_req(OP_INIT, 32'h0000_0000);
		send_req(OP_SPARE, 32'h5A5A_A5A5);

		// zero ticks per second: every update moves; speed -128
		apply_settings(127, -128, 256, 0, 0);
		repeat (3) send_req(OP_UPDATE, 32'h0000_0010);
		send_req(OP_UPDATE, 32'hFFFF_FFFF);

		// largest step, period above the cap
		apply_settings(-1, 1, 257, 511, 20'hFFFFF);
		send_req(OP_INIT, 32'h0000_0000);
		send_req(OP_UPDATE, 32'h000F_FFFE);
		send_req(OP_UPDATE, 32'h000F_FFFF);
		send_req(OP_SKIP, 32'h0000_0005);
		send_req(OP_UPDATE, 32'hFFFF_FFFF);
		send_req(OP_UPDATE, 32'h0000_0003);

		// small periods so offsets wrap both ways
		apply_settings(10, -3, 5, 7, 1000);
		send_req(OP_INIT, 32'h0000_0000);
		send_req(OP_UPDATE, 32'd100);
		send_req(OP_UPDATE, 32'd200);
		send_req(OP_UPDATE, 32'd333);
		send_req(OP_UPDATE, 32'd1000);
		send_req(OP_UPDATE, 32'd5000);
		send_req(OP_SPARE, 32'hA5A5_5A5A);

		apply_settings(20, -7, 12, 9, 1000);
		run_random(150, 0, 0, 0);
		apply_settings(-100, 45, 256, 3, 5000);
		run_random(130, 59, 0, 0);
		apply_settings(1, -128, 2, 256, 60);
		run_random(130, 0, 59, 0);
		apply_settings(127, 0, 100, 1, 1000000);
		run_random(130, 13, 13, 0);

		// hold the output long enough that the block backs up its input
		apply_settings(0, 127, 0, 200, 1);
		@(posedge clk);
		hold_request = 400;
		@(negedge clk);
		run_random(60, 0, 0, 0);

		apply_settings($urandom(), $urandom(), $urandom_range(511, 0), $urandom_range(511, 0),
			$urandom_range(4000, 1));
		run_random(150, 59, 59, 50);

		req_valid <= 1'b0;
		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (60) @(negedge clk);
		if (outstanding != 0) $error("%0d responses never arrived", outstanding);

		$display("covered %0d requests, %0d responses checked, %0d register settings",
			sent_count, checked_count, settings_count);
		$display("mixes: no idling, sender gaps, receiver stalls, both, long output hold");
		if (fail_count == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/dpst_pkg.sv
rtl/dpst_div.sv
rtl/dpst_core.sv
rtl/dual_pattern_scroll_timer_top.sv
tb/dpst_checker.sv
tb/tb_top.sv
